[sv/tcce_pkg.sv]
// Shared constants, codes and controller/datapath handshake types of the cursor engine.
package tcce_pkg;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam int TAB_STOP = 8;
    localparam int TAB_BITS = $clog2(TAB_STOP);

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd25;

    localparam int ADDR_W = 3;
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
    localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd1;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd2;
    localparam logic [OP_W-1:0] OP_SPACE     = 3'd3;
    localparam logic [OP_W-1:0] OP_PRINT     = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            last;
        logic            load_colors;
    } tcce_cmd_t;

    typedef struct packed {
        logic              is_newline;
        logic              is_backspace;
        logic              is_tab;
        logic [TAB_BITS:0] tab_count;
        logic              out_free;
    } tcce_status_t;

endpackage

[sv/tcce_if.sv]
// Valid/ready channel interfaces for character words in and draw words out.
interface tcce_char_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;
    logic [31:0] fg_color;
    logic [31:0] bg_color;

    modport source (output valid, output char_code, output fg_color, output bg_color,
                    input ready);
    modport sink (input valid, input char_code, input fg_color, input bg_color,
                  output ready);
endinterface

interface tcce_draw_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [7:0]  glyph;
    logic [31:0] draw_fg;
    logic [31:0] draw_bg;
    logic        last;

    modport source (output valid, output cell_column, output cell_row, output glyph,
                    output draw_fg, output draw_bg, output last, input ready);
    modport sink (input valid, input cell_column, input cell_row, input glyph,
                  input draw_fg, input draw_bg, input last, output ready);
endinterface

[sv/text_console_cursor_engine.sv]
// Top level of the text console cursor engine: configuration registers and the two units.
//
// Usage: character words (char_code, fg_color, bg_color) enter on char_in; draw words
// (cell_column, cell_row, glyph, draw_fg, draw_bg, last) leave on draw_out. Both are
// valid/ready channels; a word moves when valid and ready are high at a clock edge.
// A newline moves the cursor and produces no draw word. Backspace and printable
// characters produce one draw word, a tab produces one to eight spaces; the final
// word caused by a character has last set.
// The first draw word of a character is valid in the cycle after the character is
// accepted. Throughput: one character per cycle for newline, backspace and printable
// characters and one space of a tab per cycle while the receiver keeps up; a tab holds
// the input until its last space, paced by the single output register in the datapath.
// The output register keeps accepting while a finished word is taken in the same
// cycle; when the receiver stalls, the word holds and char_in.ready drops.
// Reset clears the cursor to column 0, row 0 and sets the screen to 80 by 25 cells.
// The user writes columns (address 0) and rows (address 4) over the APB port only while
// the engine is idle; the block does not enforce this. Reads return the current values.
module text_console_cursor_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    tcce_char_if.sink                   char_in,
    tcce_draw_if.source                 draw_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [7:0] columns_reg;
    logic [7:0] rows_reg;
    logic       cfg_write;
    logic       reg_index;

    tcce_pkg::tcce_cmd_t    cmd;
    tcce_pkg::tcce_status_t status;

    // The register index is the word address; byte offsets within a word are ignored.
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= tcce_pkg::COLUMNS_RESET;
            rows_reg    <= tcce_pkg::ROWS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                tcce_pkg::REG_COLUMNS: columns_reg <= pwdata[7:0];
                tcce_pkg::REG_ROWS:    rows_reg    <= pwdata[7:0];
                default:               columns_reg <= columns_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            tcce_pkg::REG_COLUMNS: prdata = {24'd0, columns_reg};
            tcce_pkg::REG_ROWS:    prdata = {24'd0, rows_reg};
            default:               prdata = '0;
        endcase
    end

    // The controller decides what each cycle does; the datapath moves the cursor and
    // loads the draw word.
    tcce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tcce_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .columns   (columns_reg),
        .rows      (rows_reg),
        .char_code (char_in.char_code),
        .fg_color  (char_in.fg_color),
        .bg_color  (char_in.bg_color),
        .cmd       (cmd),
        .status    (status),
        .draw_out  (draw_out)
    );

`ifndef SYNTHESIS
    // While a tab still has spaces to go, no new character may be taken.
    a_tab_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (draw_out.valid && !draw_out.last) |-> !char_in.ready)
        else $error("character accepted in the middle of a tab");

    // Once a non-final space of a tab leaves, the next one follows at once.
    a_tab_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (draw_out.valid && draw_out.ready && !draw_out.last) |=> draw_out.valid)
        else $error("gap between the spaces of a tab");

    // Only tab fill can produce a non-final word, and it always draws a space.
    a_glyph_last: assert property (@(posedge clk) disable iff (!rst_n)
        (draw_out.valid && (draw_out.glyph != tcce_pkg::CH_SPACE)) |-> draw_out.last)
        else $error("printable word without last marker");
`endif

endmodule

[sv/tcce_ctrl.sv]
// Controller state machine: accepts characters and sequences the spaces of a tab.
module tcce_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tcce_pkg::tcce_status_t status,
    output tcce_pkg::tcce_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TAB  = 1'b1;

    logic                      state_reg, state_next;
    logic [tcce_pkg::TAB_BITS-1:0] remain_reg, remain_next;

    assign in_ready = (state_reg == ST_IDLE) && status.out_free;

    always_comb
    begin
        state_next      = state_reg;
        remain_next     = remain_reg;
        cmd.op          = tcce_pkg::OP_NONE;
        cmd.last        = 1'b1;
        cmd.load_colors = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.out_free)
                begin
                    cmd.load_colors = 1'b1;
                    if (status.is_newline)
                    begin
                        cmd.op = tcce_pkg::OP_NEWLINE;
                    end
                    else if (status.is_backspace)
                    begin
                        cmd.op = tcce_pkg::OP_BACKSPACE;
                    end
                    else if (status.is_tab)
                    begin
                        cmd.op      = tcce_pkg::OP_SPACE;
                        cmd.last    = (status.tab_count == (tcce_pkg::TAB_BITS + 1)'(1));
                        remain_next = tcce_pkg::TAB_BITS'(status.tab_count - 1'b1);
                        if (!cmd.last)
                        begin
                            state_next = ST_TAB;
                        end
                    end
                    else
                    begin
                        cmd.op = tcce_pkg::OP_PRINT;
                    end
                end
            end
            ST_TAB:
            begin
                if (status.out_free)
                begin
                    cmd.op      = tcce_pkg::OP_SPACE;
                    cmd.last    = (remain_reg == tcce_pkg::TAB_BITS'(1));
                    remain_next = remain_reg - 1'b1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

endmodule

[sv/tcce_datapath.sv]
// Datapath: cursor registers, wrap logic and the registered draw word output.
module tcce_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             columns,
    input  logic [7:0]             rows,
    input  logic [7:0]             char_code,
    input  logic [31:0]            fg_color,
    input  logic [31:0]            bg_color,
    input  tcce_pkg::tcce_cmd_t    cmd,
    output tcce_pkg::tcce_status_t status,
    tcce_draw_if.source            draw_out
);

    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic        out_valid_reg;
    logic [7:0]  cell_column_reg, cell_row_reg, glyph_reg;
    logic [31:0] draw_fg_reg, draw_bg_reg;
    logic        last_reg;

    logic [7:0]  emit_col, emit_row;
    logic [8:0]  move_col;
    logic [8:0]  move_row;
    logic        emits;

    // Column wraps into the next row, then the row wraps to zero. Compares are done on
    // the widened values so an increment past 255 always wraps.
    function automatic logic [15:0] wrap(input logic [8:0] c, input logic [8:0] r,
                                         input logic [7:0] ncol, input logic [7:0] nrow);
        logic [9:0] rr;
        logic [7:0] cc;
        begin
            rr = {1'b0, r};
            cc = c[7:0];
            if (c >= {1'b0, ncol})
            begin
                cc = '0;
                rr = rr + 10'd1;
            end
            if (rr >= {2'b00, nrow})
            begin
                rr = '0;
            end
            wrap = {rr[7:0], cc};
        end
    endfunction

    assign status.is_newline   = (char_code == tcce_pkg::CH_NEWLINE);
    assign status.is_backspace = (char_code == tcce_pkg::CH_BACKSPACE);
    assign status.is_tab       = (char_code == tcce_pkg::CH_TAB);
    assign status.tab_count    = (tcce_pkg::TAB_BITS + 1)'(tcce_pkg::TAB_STOP)
                                 - {1'b0, col_reg[tcce_pkg::TAB_BITS-1:0]};
    assign status.out_free     = !out_valid_reg || draw_out.ready;

    always_comb
    begin
        emit_col = col_reg;
        emit_row = row_reg;
        move_col = {1'b0, col_reg} + 9'd1;
        move_row = {1'b0, row_reg};
        emits    = 1'b0;
        case (cmd.op)
            tcce_pkg::OP_NEWLINE:
            begin
                move_col = '0;
                move_row = {1'b0, row_reg} + 9'd1;
            end
            tcce_pkg::OP_BACKSPACE:
            begin
                emits = 1'b1;
                if (col_reg == 8'd0)
                begin
                    emit_col = columns - 8'd1;
                    emit_row = (row_reg == 8'd0) ? (rows - 8'd1) : (row_reg - 8'd1);
                end
                else
                begin
                    emit_col = col_reg - 8'd1;
                end
                move_col = {1'b0, emit_col};
                move_row = {1'b0, emit_row};
            end
            tcce_pkg::OP_SPACE, tcce_pkg::OP_PRINT:
            begin
                emits = 1'b1;
            end
            default:
            begin
                move_col = {1'b0, col_reg};
            end
        endcase
        if (cmd.op == tcce_pkg::OP_NONE)
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
        else
        begin
            {row_next, col_next} = wrap(move_col, move_row, columns, rows);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (emits)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (draw_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emits)
        begin
            cell_column_reg <= emit_col;
            cell_row_reg    <= emit_row;
            glyph_reg       <= (cmd.op == tcce_pkg::OP_PRINT) ? char_code : tcce_pkg::CH_SPACE;
            last_reg        <= cmd.last;
            if (cmd.load_colors)
            begin
                draw_fg_reg <= fg_color;
                draw_bg_reg <= bg_color;
            end
        end
    end

    assign draw_out.valid       = out_valid_reg;
    assign draw_out.cell_column = cell_column_reg;
    assign draw_out.cell_row    = cell_row_reg;
    assign draw_out.glyph       = glyph_reg;
    assign draw_out.draw_fg     = draw_fg_reg;
    assign draw_out.draw_bg     = draw_bg_reg;
    assign draw_out.last        = last_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench of the text console cursor engine: directed table, then random phases.
module testbench;

    // Byte addresses of the two screen size registers on the APB port.
    localparam logic [tcce_pkg::ADDR_W-1:0] ADDR_COLUMNS = 3'd0;
    localparam logic [tcce_pkg::ADDR_W-1:0] ADDR_ROWS    = 3'd4;

    // Cycles to let pass after the last draw word before a register write or the end,
    // the length of the long receiver hold-off, and the watchdog limit on cycles in
    // which no word and no register access moves.
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 25;

    // One draw word as it leaves the engine.
    typedef struct packed {
        logic [7:0]  cell_column;
        logic [7:0]  cell_row;
        logic [7:0]  glyph;
        logic [31:0] draw_fg;
        logic [31:0] draw_bg;
        logic        last;
    } draw_word_t;

    typedef enum logic {ROW_CHAR, ROW_SCREEN} row_kind_t;

    // One line of the directed table: either a character word or a new screen size.
    // Where typed is set, the first draw word of the character is given by hand.
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  char_code;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [7:0]  new_columns;
        logic [7:0]  new_rows;
        bit          typed;
        draw_word_t  first_draw;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tcce_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tcce_char_if char_bus();
    tcce_draw_if draw_bus();

    text_console_cursor_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .draw_out (draw_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Cursor tracker: its own copy of the screen size and the cursor position.
    logic [7:0] scr_columns;
    logic [7:0] scr_rows;
    int         cur_col;
    int         cur_row;

    // Draw words that the engine still owes, oldest first.
    draw_word_t pending_draws[$];
    table_row_t directed[$];

    int  err_count;
    int  idle_cycles;
    int  words_taken;
    bit  send_burst;
    bit  take_burst;
    bit  hold_req;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Any failure goes through here; only the first few are shown in full.
    function automatic void note_mismatch(string what);
        err_count++;
        if (err_count <= 10)
        begin
            $display("mismatch %0d: %s", err_count, what);
        end
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // Wrap rule of the cursor: a column at or past the row width starts the next row,
    // then a row at or past the screen height goes back to the top. Both compare the
    // full integer before it is cut to 8 bits.
    function automatic void wrap_cursor(inout int col, inout int row);
        if (col >= int'(scr_columns))
        begin
            col = 0;
            row = row + 1;
        end
        if (row >= int'(scr_rows))
        begin
            row = 0;
        end
        col = col & 255;
        row = row & 255;
    endfunction

    function automatic void push_draw(int col, int row, logic [7:0] glyph,
                                      logic [31:0] fg, logic [31:0] bg, logic last);
        draw_word_t w;
        w.cell_column = col[7:0];
        w.cell_row    = row[7:0];
        w.glyph       = glyph;
        w.draw_fg     = fg;
        w.draw_bg     = bg;
        w.last        = last;
        pending_draws.push_back(w);
    endfunction

    // Moves the cursor for one accepted character and queues the draw words it causes.
    // Returns how many words were queued.
    function automatic int predict_draws(logic [7:0] code, logic [31:0] fg, logic [31:0] bg);
        int col;
        int row;
        int count;
        col = cur_col;
        row = cur_row;
        count = 0;
        if (code == tcce_pkg::CH_NEWLINE)
        begin
            col = 0;
            row = row + 1;
            wrap_cursor(col, row);
        end
        else if (code == tcce_pkg::CH_BACKSPACE)
        begin
            // Stepping back from column 0 lands on the last column of the row above,
            // or of the bottom row when already at the top. Zero sizes give 255.
            if (col == 0)
            begin
                col = (int'(scr_columns) - 1) & 255;
                row = (row == 0) ? ((int'(scr_rows) - 1) & 255) : row - 1;
            end
            else
            begin
                col = col - 1;
            end
            push_draw(col, row, tcce_pkg::CH_SPACE, fg, bg, 1'b1);
            count = 1;
            wrap_cursor(col, row);
        end
        else if (code == tcce_pkg::CH_TAB)
        begin
            // The number of spaces is fixed on arrival, even if the row wraps on the way.
            count = tcce_pkg::TAB_STOP - (col % tcce_pkg::TAB_STOP);
            for (int i = 0; i < count; i++)
            begin
                push_draw(col, row, tcce_pkg::CH_SPACE, fg, bg, (i + 1 == count));
                col = col + 1;
                wrap_cursor(col, row);
            end
        end
        else
        begin
            push_draw(col, row, code, fg, bg, 1'b1);
            count = 1;
            col = col + 1;
            wrap_cursor(col, row);
        end
        cur_col = col;
        cur_row = row;
        return count;
    endfunction

    // Offers one character word after a random gap and waits until it is taken.
    // Valid is left high so that a following word without a gap needs no new edge.
    task automatic send_char(input logic [7:0] code, input logic [31:0] fg,
                             input logic [31:0] bg, output int queued);
        int gap;
        gap = draw_gap(send_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        char_bus.fg_color  <= fg;
        char_bus.bg_color  <= bg;
        @(posedge clk);
        while (!char_bus.ready) @(posedge clk);
        queued = predict_draws(code, fg, bg);
    endtask

    task automatic park_sender();
        @(negedge clk);
        char_bus.valid <= 1'b0;
    endtask

    // Waits for every owed draw word, then lets the engine settle.
    task automatic wait_drained();
        while (pending_draws.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready. The bus is left
    // selected so that a following transfer starts cleanly at the next falling edge.
    task automatic apb_transfer(input logic wr, input logic [tcce_pkg::ADDR_W-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
    endtask

    // Reads both size registers back, compares them and releases the bus.
    task automatic check_screen_regs();
        logic [31:0] rd;
        apb_transfer(1'b0, ADDR_COLUMNS, 32'h0, rd);
        if (rd[7:0] !== scr_columns)
        begin
            note_mismatch($sformatf("columns reads %0d, expected %0d", rd[7:0], scr_columns));
        end
        apb_transfer(1'b0, ADDR_ROWS, 32'h0, rd);
        if (rd[7:0] !== scr_rows)
        begin
            note_mismatch($sformatf("rows reads %0d, expected %0d", rd[7:0], scr_rows));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Changes the screen size with the engine idle. The upper data bits are noise
    // that the 8-bit registers must drop.
    task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
        logic [31:0] wdata;
        logic [31:0] rd;
        park_sender();
        wait_drained();
        wdata = $urandom();
        wdata[7:0] = cols;
        apb_transfer(1'b1, ADDR_COLUMNS, wdata, rd);
        scr_columns = cols;
        wdata = $urandom();
        wdata[7:0] = rows;
        apb_transfer(1'b1, ADDR_ROWS, wdata, rd);
        scr_rows = rows;
        check_screen_regs();
    endtask

    function automatic void row_char(logic [7:0] code, logic [31:0] fg, logic [31:0] bg);
        table_row_t r;
        r.kind = ROW_CHAR;
        r.char_code = code;
        r.fg_color = fg;
        r.bg_color = bg;
        r.new_columns = 8'd0;
        r.new_rows = 8'd0;
        r.typed = 1'b0;
        r.first_draw = '0;
        directed.push_back(r);
    endfunction

    // A character whose first draw word is written out by hand.
    function automatic void row_typed(logic [7:0] code, logic [31:0] fg, logic [31:0] bg,
                                      logic [7:0] col, logic [7:0] row,
                                      logic [7:0] glyph, logic last);
        row_char(code, fg, bg);
        directed[$].typed = 1'b1;
        directed[$].first_draw = '{col, row, glyph, fg, bg, last};
    endfunction

    function automatic void row_screen(logic [7:0] cols, logic [7:0] rows);
        row_char(8'd0, 32'h0, 32'h0);
        directed[$].kind = ROW_SCREEN;
        directed[$].new_columns = cols;
        directed[$].new_rows = rows;
    endfunction

    // Random characters: mostly printable text, with plenty of control codes and
    // the odd byte from anywhere in the range.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return tcce_pkg::CH_NEWLINE;
        else if (r < 26)
            return tcce_pkg::CH_BACKSPACE;
        else if (r < 40)
            return tcce_pkg::CH_TAB;
        else if (r < 55)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(33, 126));
    endfunction

    // Scoreboard: every draw word taken is checked against the oldest one owed.
    always @(posedge clk)
    begin : draw_check
        draw_word_t got;
        draw_word_t want;
        if (rst_n && draw_bus.valid && draw_bus.ready)
        begin
            got = '{draw_bus.cell_column, draw_bus.cell_row, draw_bus.glyph,
                    draw_bus.draw_fg, draw_bus.draw_bg, draw_bus.last};
            if (pending_draws.size() == 0)
            begin
                note_mismatch($sformatf("unexpected draw word col %0d row %0d glyph %0d",
                                        got.cell_column, got.cell_row, got.glyph));
            end
            else
            begin
                want = pending_draws.pop_front();
                if (got !== want)
                begin
                    note_mismatch({
                        $sformatf("draw col %0d/%0d row %0d/%0d glyph %0d/%0d",
                                  got.cell_column, want.cell_column, got.cell_row,
                                  want.cell_row, got.glyph, want.glyph),
                        $sformatf(" fg %h/%h bg %h/%h last %b/%b (got/expected)",
                                  got.draw_fg, want.draw_fg, got.draw_bg, want.draw_bg,
                                  got.last, want.last)});
                end
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long is a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (char_bus.valid && char_bus.ready) || (draw_bus.valid && draw_bus.ready)
            || (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Draw word receiver. It waits a random number of cycles before each word, has
    // stretches with no waiting at all, and once holds off for a long stretch so that
    // the engine fills up and stalls its character input.
    initial
    begin : receiver
        int gap;
        draw_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
            begin
                gap = draw_gap(take_burst);
            end
            @(negedge clk);
            if (gap > 0)
            begin
                draw_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            draw_bus.ready <= 1'b1;
            @(posedge clk);
            while (!draw_bus.valid) @(posedge clk);
            words_taken++;
            take_burst = ((words_taken / 15) % 3) == 1;
        end
    end

    // Stimulus and end of the run.
    initial
    begin : stimulus
        int         queued;
        int         idx;
        logic [7:0] phase_cols[PHASES];
        logic [7:0] phase_rows[PHASES];

        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        char_bus.valid = 1'b0;
        char_bus.char_code = 8'd0;
        char_bus.fg_color = 32'd0;
        char_bus.bg_color = 32'd0;
        err_count = 0;
        idle_cycles = 0;
        words_taken = 0;
        send_burst = 1'b0;
        take_burst = 1'b0;
        hold_req = 1'b0;
        scr_columns = tcce_pkg::COLUMNS_RESET;
        scr_rows = tcce_pkg::ROWS_RESET;
        cur_col = 0;
        cur_row = 0;

        // Directed part. After reset the screen is 80 by 25 with the cursor at the
        // top left, so the first few words can be written out by hand.
        row_typed("A", 32'h0000_0000, 32'hFFFF_FFFF, 8'd0, 8'd0, "A", 1'b1);
        row_typed(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 8'd0, 8'hFF, 1'b1);
        row_typed(tcce_pkg::CH_BACKSPACE, 32'h5555_AAAA, 32'hAAAA_5555,
                  8'd1, 8'd0, tcce_pkg::CH_SPACE, 1'b1);
        row_typed(8'h00, 32'h1234_5678, 32'h8765_4321, 8'd1, 8'd0, 8'h00, 1'b1);
        // A tab from column 2 fills six spaces; only the first is typed in.
        row_typed(tcce_pkg::CH_TAB, 32'hDEAD_BEEF, 32'h0BAD_F00D,
                  8'd2, 8'd0, tcce_pkg::CH_SPACE, 1'b0);
        row_char(tcce_pkg::CH_NEWLINE, 32'h0, 32'h0);
        // Backspace at the start of row 1 goes to the last column of row 0.
        row_typed(tcce_pkg::CH_BACKSPACE, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                  8'd79, 8'd0, tcce_pkg::CH_SPACE, 1'b1);
        row_char("z", 32'hCAFE_0001, 32'h0000_CAFE);
        row_char(tcce_pkg::CH_TAB, 32'h0000_0001, 32'h8000_0000);
        row_char("x", 32'h7FFF_FFFF, 32'h8000_0001);
        // Shrinking the screen under the cursor: the next draw is still at the old
        // spot, and the wrap then brings the cursor back to the top left.
        row_screen(8'd4, 8'd2);
        row_char("c", 32'h0000_FFFF, 32'hFFFF_0000);
        // Backspace at the top left goes to the last cell of the bottom row.
        row_typed(tcce_pkg::CH_BACKSPACE, 32'h1111_1111, 32'h2222_2222,
                  8'd3, 8'd1, tcce_pkg::CH_SPACE, 1'b1);
        // This tab runs over the row end and over the bottom of the screen.
        row_char(tcce_pkg::CH_TAB, 32'h3333_3333, 32'h4444_4444);
        row_screen(8'd255, 8'd255);
        row_char(tcce_pkg::CH_NEWLINE, 32'h0, 32'h0);
        row_char(8'd126, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        row_screen(8'd1, 8'd1);
        row_char("m", 32'h6666_6666, 32'h9999_9999);
        row_char(tcce_pkg::CH_TAB, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        row_char(tcce_pkg::CH_BACKSPACE, 32'h0000_0000, 32'h0000_0000);
        // Zero sizes: every wrap check fires and a backspace sees 255.
        row_screen(8'd0, 8'd0);
        row_char("k", 32'h0101_0101, 32'h1010_1010);
        row_char(tcce_pkg::CH_BACKSPACE, 32'h0202_0202, 32'h2020_2020);
        row_char(tcce_pkg::CH_TAB, 32'h0303_0303, 32'h3030_3030);
        row_char(tcce_pkg::CH_NEWLINE, 32'h0, 32'h0);
        row_char(8'd128, 32'h0404_0404, 32'h4040_4040);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // The size registers must come out of reset at 80 by 25.
        check_screen_regs();

        foreach (directed[k])
        begin
            if (directed[k].kind == ROW_SCREEN)
            begin
                set_screen(directed[k].new_columns, directed[k].new_rows);
            end
            else
            begin
                send_char(directed[k].char_code, directed[k].fg_color, directed[k].bg_color,
                          queued);
                if (directed[k].typed && queued > 0)
                begin
                    idx = pending_draws.size() - queued;
                    pending_draws[idx] = directed[k].first_draw;
                end
            end
        end

        // Random part: one phase per screen size, the extremes among them and the
        // last one drawn at random.
        phase_cols = '{8'd80, 8'd1, 8'd255, 8'd7, 8'd0, 8'd16, 8'd255, 8'd1};
        phase_rows = '{8'd25, 8'd1, 8'd255, 8'd3, 8'd0, 8'd5, 8'd1, 8'd255};
        phase_cols[PHASES-1] = 8'($urandom_range(1, 255));
        phase_rows[PHASES-1] = 8'($urandom_range(1, 255));

        for (int p = 0; p < PHASES; p++)
        begin
            set_screen(phase_cols[p], phase_rows[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_burst = ((i / 9) % 3) == 2;
                // In the third phase the receiver holds off for a long stretch while
                // characters keep coming back to back.
                if (p == 2 && i == 4)
                begin
                    hold_req = 1'b1;
                end
                if (p == 2 && i >= 4 && i < 20)
                begin
                    send_burst = 1'b1;
                end
                send_char(pick_char(), $urandom(), $urandom(), queued);
            end
        end

        park_sender();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_draws.size() != 0)
        begin
            note_mismatch($sformatf("%0d draw words never arrived", pending_draws.size()));
        end

        if (err_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/tcce_pkg.sv
sv/tcce_if.sv
sv/tcce_ctrl.sv
sv/tcce_datapath.sv
sv/text_console_cursor_engine.sv
tb/testbench.sv
